@@ design/assert_macros.svh @@
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the tracker checker
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/cvkt_pkg.sv @@
// ------------------------------------------------------------------------
// cvkt_pkg
// types and constants of the constant-velocity tracker
// ------------------------------------------------------------------------
package cvkt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DT_W          = 25;
    localparam int NOISE_W       = 17;
    localparam int PIX_W         = 16;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_MEASURE = 2'd1;
    localparam logic [1:0] KIND_COAST   = 2'd2;

    localparam logic [1:0] REG_TIME_STEP = 2'd0;
    localparam logic [1:0] REG_PROC_NOISE = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

    localparam logic [31:0] DT_RESET = 32'd65536;
    localparam logic [31:0] Q_RESET  = 32'd66;
    localparam logic [31:0] R_RESET  = 32'd655;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // micro-op sequence per axis
    typedef enum logic [3:0] {
        OP_XP,
        OP_B,
        OP_T,
        OP_A,
        OP_DIV0,
        OP_DIV1,
        OP_X,
        OP_V,
        OP_P00,
        OP_P01,
        OP_P11,
        OP_END
    } op_t;

endpackage

@@ design/constant_velocity_kalman_tracker.sv @@
// ------------------------------------------------------------------------
// constant_velocity_kalman_tracker
// two-axis constant-velocity kalman filter in signed fixed point
// ------------------------------------------------------------------------
// One item is taken at a time and one result item is returned for each. A
// start or unused item passes straight from acceptance to the output state. A
// measure or coast item runs both axes through a single shared multiplier,
// one product per cycle, and a shared restoring divider that produces one
// quotient bit per cycle (32 + FRAC_BITS + 2 bits, between a set-up and a
// finishing step) for each of the two gains per axis. The output register
// holds the result until it is taken, and the next item is accepted only
// once the result has left.
module constant_velocity_kalman_tracker #(
    parameter int FRAC_BITS = cvkt_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // pos_x, pos_y, vel_x, vel_y
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [127:0] m_tdata,  // post_pos_x, post_pos_y, post_vel_x,
                                   // post_vel_y, pred_pos_x, pred_pos_y,
                                   // pred_vel_x, pred_vel_y
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int QW   = 32 + FRAC_BITS + 2;  // dividend width
    localparam int QCW  = $clog2(QW + 1);
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    cvkt_pkg::state_t state_reg, state_next;
    cvkt_pkg::op_t    op_reg;

    logic [cvkt_pkg::DT_W-1:0]    dt_reg;
    logic [cvkt_pkg::NOISE_W-1:0] q_reg, r_reg;

    logic signed [31:0] post_reg [4];
    logic signed [31:0] pred_reg [4];
    logic signed [31:0] cov_reg  [6];

    logic        axis_reg;
    logic [1:0]  kind_reg;
    logic signed [31:0] meas_reg [2];

    logic signed [31:0] xp_reg, b_reg, t_reg, a_reg, c_reg, k0_reg, k1_reg;
    logic signed [32:0] e_reg;

    // divider
    logic [QW-1:0] dvd_reg;
    logic [QW-1:0] rem_reg;
    logic [QW-1:0] dvs_reg;
    logic [QCW-1:0] dcnt_reg;
    logic          dneg_reg;
    logic          dzero_reg;

    logic          mvalid_reg;
    logic [127:0]  mdata_reg;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       sat32 = 32'sh7fffffff;
        else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
        else                           sat32 = v[31:0];
    endfunction

    function automatic logic [15:0] to_pix(input logic signed [31:0] v);
        logic signed [31:0] a;
        logic signed [31:0] p;
        a = (v < 0) ? (v + 32'(ONE - 64'sd1)) : v;
        p = a >>> FRAC_BITS;
        if (p > 32'sd32767)       to_pix = 16'h7fff;
        else if (p < -32'sd32768) to_pix = 16'h8000;
        else                      to_pix = p[15:0];
    endfunction

    // shared multiplier: floor(ma * mb / ONE)
    logic signed [32:0] ma, mb;
    logic signed [65:0] mprod;
    logic signed [65:0] mres;
    logic signed [31:0] cov0, cov1, cov2, xs, vs;

    always_comb begin
        cov0 = axis_reg ? cov_reg[3] : cov_reg[0];
        cov1 = axis_reg ? cov_reg[4] : cov_reg[1];
        cov2 = axis_reg ? cov_reg[5] : cov_reg[2];
        xs   = axis_reg ? post_reg[1] : post_reg[0];
        vs   = axis_reg ? post_reg[3] : post_reg[2];
        ma = {1'b0, 7'd0, dt_reg};
        mb = 33'(vs);
        unique case (op_reg)
            cvkt_pkg::OP_XP:  mb = 33'(vs);
            cvkt_pkg::OP_B:   mb = 33'(cov2);
            cvkt_pkg::OP_T:   mb = 33'(cov1);
            cvkt_pkg::OP_A:   mb = 33'(b_reg);
            cvkt_pkg::OP_X:   begin ma = 33'(k0_reg); mb = e_reg; end
            cvkt_pkg::OP_V:   begin ma = 33'(k1_reg); mb = e_reg; end
            cvkt_pkg::OP_P00: begin ma = 33'(k0_reg); mb = 33'(a_reg); end
            cvkt_pkg::OP_P01: begin ma = 33'(k0_reg); mb = 33'(b_reg); end
            cvkt_pkg::OP_P11: begin ma = 33'(k1_reg); mb = 33'(b_reg); end
            default: ;
        endcase
        mprod = ma * mb;
        mres  = mprod >>> FRAC_BITS;
    end

    // innovation z - xp, kept at its full 33-bit width
    logic signed [32:0] e_full;
    assign e_full = 33'(meas_reg[axis_reg]) - 33'(xp_reg);

    // divider step
    logic [QW-1:0] rem_sh, rem_sub;
    logic          rem_ge;
    always_comb begin
        rem_sh  = {rem_reg[QW-2:0], dvd_reg[QW-1]};
        rem_ge  = rem_sh >= dvs_reg;
        rem_sub = rem_ge ? (rem_sh - dvs_reg) : rem_sh;
    end

    logic signed [QW:0] quot_s;
    logic signed [31:0] quot_sat;
    always_comb begin
        quot_s = dneg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
        if (dzero_reg)                                 quot_sat = '0;
        else if (quot_s > (QW+1)'(64'sd2147483647))   quot_sat = 32'sh7fffffff;
        else if (quot_s < -(QW+1)'(64'sd2147483648))  quot_sat = 32'sh80000000;
        else                                           quot_sat = quot_s[31:0];
    end

    logic signed [33:0] s_sum;
    assign s_sum = 34'(a_reg) + 34'($signed({1'b0, r_reg}));

    logic accept_in;
    assign s_tready  = (state_reg == cvkt_pkg::ST_IDLE) && !mvalid_reg;
    assign accept_in = s_tvalid && s_tready;
    assign cfg_ready = (state_reg == cvkt_pkg::ST_IDLE);
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cvkt_pkg::ST_IDLE: begin
                if (accept_in) begin
                    if (s_tuser == cvkt_pkg::KIND_MEASURE || s_tuser == cvkt_pkg::KIND_COAST)
                        state_next = cvkt_pkg::ST_MUL;
                    else
                        state_next = cvkt_pkg::ST_OUT;
                end
            end
            cvkt_pkg::ST_MUL: begin
                if (op_reg == cvkt_pkg::OP_DIV0 || op_reg == cvkt_pkg::OP_DIV1)
                    state_next = cvkt_pkg::ST_DIV;
                else if (op_reg == cvkt_pkg::OP_END && axis_reg)
                    state_next = cvkt_pkg::ST_OUT;
            end
            cvkt_pkg::ST_DIV: begin
                if (dcnt_reg == '0) state_next = cvkt_pkg::ST_MUL;
            end
            cvkt_pkg::ST_OUT: state_next = cvkt_pkg::ST_IDLE;
            default: state_next = cvkt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= cvkt_pkg::ST_IDLE;
            op_reg     <= cvkt_pkg::OP_XP;
            axis_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            dt_reg     <= cvkt_pkg::DT_RESET[cvkt_pkg::DT_W-1:0];
            q_reg      <= cvkt_pkg::Q_RESET[cvkt_pkg::NOISE_W-1:0];
            r_reg      <= cvkt_pkg::R_RESET[cvkt_pkg::NOISE_W-1:0];
            for (int i = 0; i < 4; i++) begin
                post_reg[i] <= '0;
                pred_reg[i] <= '0;
            end
            for (int i = 0; i < 6; i++) cov_reg[i] <= '0;
            dcnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) mvalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    cvkt_pkg::REG_TIME_STEP:  dt_reg <= cfg_data[cvkt_pkg::DT_W-1:0];
                    cvkt_pkg::REG_PROC_NOISE: q_reg <= cfg_data[cvkt_pkg::NOISE_W-1:0];
                    cvkt_pkg::REG_MEAS_NOISE: r_reg <= cfg_data[cvkt_pkg::NOISE_W-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                cvkt_pkg::ST_IDLE: begin
                    if (accept_in) begin
                        kind_reg <= s_tuser;
                        axis_reg <= 1'b0;
                        op_reg   <= cvkt_pkg::OP_XP;
                        meas_reg[1] <= sat32(66'(signed'(s_tdata[31:16])) <<< FRAC_BITS);
                        meas_reg[0] <= sat32(66'(signed'(s_tdata[15:0])) <<< FRAC_BITS);
                        if (s_tuser == cvkt_pkg::KIND_START) begin
                            post_reg[0] <= sat32(66'(signed'(s_tdata[15:0])) <<< FRAC_BITS);
                            post_reg[1] <= sat32(66'(signed'(s_tdata[31:16])) <<< FRAC_BITS);
                            post_reg[2] <= sat32(66'(signed'(s_tdata[47:32])) <<< FRAC_BITS);
                            post_reg[3] <= sat32(66'(signed'(s_tdata[63:48])) <<< FRAC_BITS);
                            pred_reg[0] <= sat32(66'(signed'(s_tdata[15:0])) <<< FRAC_BITS);
                            pred_reg[1] <= sat32(66'(signed'(s_tdata[31:16])) <<< FRAC_BITS);
                            pred_reg[2] <= sat32(66'(signed'(s_tdata[47:32])) <<< FRAC_BITS);
                            pred_reg[3] <= sat32(66'(signed'(s_tdata[63:48])) <<< FRAC_BITS);
                            cov_reg[0] <= 32'(ONE);
                            cov_reg[1] <= '0;
                            cov_reg[2] <= 32'(ONE);
                            cov_reg[3] <= 32'(ONE);
                            cov_reg[4] <= '0;
                            cov_reg[5] <= 32'(ONE);
                        end
                    end
                end
                cvkt_pkg::ST_MUL: begin
                    unique case (op_reg)
                        cvkt_pkg::OP_XP: begin
                            xp_reg <= sat32(66'(xs) + mres);
                            op_reg <= cvkt_pkg::OP_B;
                        end
                        cvkt_pkg::OP_B: begin
                            b_reg <= sat32(66'(cov1) + mres);
                            c_reg <= sat32(66'(cov2) + 66'($signed({1'b0, q_reg})));
                            if (kind_reg == cvkt_pkg::KIND_COAST) meas_reg[axis_reg] <= xp_reg;
                            op_reg <= cvkt_pkg::OP_T;
                        end
                        cvkt_pkg::OP_T: begin
                            t_reg  <= sat32(66'(cov0) + mres);
                            op_reg <= cvkt_pkg::OP_A;
                        end
                        cvkt_pkg::OP_A: begin
                            a_reg  <= sat32(66'(t_reg) + mres + 66'($signed({1'b0, q_reg})));
                            e_reg  <= e_full;
                            op_reg <= cvkt_pkg::OP_DIV0;
                        end
                        cvkt_pkg::OP_DIV0, cvkt_pkg::OP_DIV1: begin
                            logic signed [QW:0] num;
                            logic signed [QW:0] den;
                            num = (op_reg == cvkt_pkg::OP_DIV0)
                                ? ((QW+1)'(a_reg) <<< FRAC_BITS)
                                : ((QW+1)'(b_reg) <<< FRAC_BITS);
                            den = (QW+1)'(s_sum);
                            dvd_reg   <= num[QW] ? QW'(-num) : QW'(num);
                            dvs_reg   <= den[QW] ? QW'(-den) : QW'(den);
                            dneg_reg  <= num[QW] ^ den[QW];
                            dzero_reg <= (s_sum == '0);
                            rem_reg   <= '0;
                            dcnt_reg  <= QCW'(QW);
                        end
                        cvkt_pkg::OP_X: begin
                            post_reg[axis_reg] <= sat32(66'(xp_reg) + mres);
                            pred_reg[axis_reg] <= xp_reg;
                            op_reg <= cvkt_pkg::OP_V;
                        end
                        cvkt_pkg::OP_V: begin
                            post_reg[{1'b1, axis_reg}] <= sat32(66'(vs) + mres);
                            pred_reg[{1'b1, axis_reg}] <= vs;
                            op_reg <= cvkt_pkg::OP_P00;
                        end
                        cvkt_pkg::OP_P00: begin
                            cov_reg[axis_reg ? 3 : 0] <= sat32(66'(a_reg) - mres);
                            op_reg <= cvkt_pkg::OP_P01;
                        end
                        cvkt_pkg::OP_P01: begin
                            cov_reg[axis_reg ? 4 : 1] <= sat32(66'(b_reg) - mres);
                            op_reg <= cvkt_pkg::OP_P11;
                        end
                        cvkt_pkg::OP_P11: begin
                            cov_reg[axis_reg ? 5 : 2] <= sat32(66'(c_reg) - mres);
                            op_reg <= cvkt_pkg::OP_END;
                        end
                        cvkt_pkg::OP_END: begin
                            if (!axis_reg) begin
                                axis_reg <= 1'b1;
                                op_reg   <= cvkt_pkg::OP_XP;
                            end
                        end
                        default: ;
                    endcase
                end
                cvkt_pkg::ST_DIV: begin
                    if (dcnt_reg != '0) begin
                        rem_reg  <= rem_sub;
                        dvd_reg  <= {dvd_reg[QW-2:0], rem_ge};
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end else begin
                        if (op_reg == cvkt_pkg::OP_DIV0) begin
                            k0_reg <= quot_sat;
                            op_reg <= cvkt_pkg::OP_DIV1;
                        end else begin
                            k1_reg <= quot_sat;
                            op_reg <= cvkt_pkg::OP_X;
                        end
                    end
                end
                cvkt_pkg::ST_OUT: begin
                    mvalid_reg <= 1'b1;
                    mdata_reg  <= {to_pix(pred_reg[3]), to_pix(pred_reg[2]),
                                   to_pix(pred_reg[1]), to_pix(pred_reg[0]),
                                   to_pix(post_reg[3]), to_pix(post_reg[2]),
                                   to_pix(post_reg[1]), to_pix(post_reg[0])};
                end
                default: ;
            endcase
        end
    end

endmodule

@@ design/cvkt_checker.sv @@
// ------------------------------------------------------------------------
// cvkt_checker
// port-level checks on the tracker handshakes
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module cvkt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         cfg_ready
);

    `ASSERT_IMPL(a_no_accept_while_result, aclk, aresetn, m_tvalid, !s_tready)
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPL(a_ready_needs_cfg_idle, aclk, aresetn, s_tready, cfg_ready)

endmodule

bind constant_velocity_kalman_tracker cvkt_checker u_cvkt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_ready(cfg_ready)
);

@@ tb/constant_velocity_kalman_tracker_tb.sv @@
// ------------------------------------------------------------------------
// constant_velocity_kalman_tracker_tb
// self-checking bench for the two-axis constant-velocity tracker: start,
// measure and coast items with random idling on both sides, several noise
// and time step settings, and a predictor of the fixed-point filter
// ------------------------------------------------------------------------
module constant_velocity_kalman_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = 64'sd1 << cvkt_pkg::FRAC_BITS_DEF;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [15:0] pred_vel_y, pred_vel_x, pred_pos_y, pred_pos_x;
        logic [15:0] post_vel_y, post_vel_x, post_pos_y, post_pos_x;
    } track_out_t;

    function automatic longint sat32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        longint p;
        p = a * b;
        if (p >= 0) return p / ONE;
        return -((-p + ONE - 1) / ONE);
    endfunction

    function automatic logic [15:0] to_pix(longint v);
        longint p;
        p = v / ONE;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[15:0];
    endfunction

    class track_scoreboard;
        longint post_st[4];
        longint pred_st[4];
        longint cov[6];
        longint dt, q, r;
        track_out_t pending[$];
        int errors;

        function new();
            foreach (post_st[i]) begin
                post_st[i] = 0;
                pred_st[i] = 0;
            end
            foreach (cov[i]) cov[i] = 0;
            dt = 65536;
            q = 66;
            r = 655;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == cvkt_pkg::REG_TIME_STEP) dt = val[24:0];
            else if (idx == cvkt_pkg::REG_PROC_NOISE) q = val[16:0];
            else if (idx == cvkt_pkg::REG_MEAS_NOISE) r = val[16:0];
        endfunction

        function void filter_axis(int ax, bit coast, longint meas);
            longint x, v, xp, vp, b, t, a, c, s, k0, k1, e;
            x = post_st[ax];
            v = post_st[ax + 2];
            xp = sat32(x + fix_mul(dt, v));
            vp = v;
            b = sat32(cov[ax*3+1] + fix_mul(dt, cov[ax*3+2]));
            t = sat32(cov[ax*3] + fix_mul(dt, cov[ax*3+1]));
            a = sat32(t + fix_mul(dt, b) + q);
            c = sat32(cov[ax*3+2] + q);
            s = a + r;
            k0 = 0;
            k1 = 0;
            e = (coast ? xp : meas) - xp;
            pred_st[ax] = xp;
            pred_st[ax + 2] = vp;
            if (s != 0) begin
                k0 = sat32(a * ONE / s);
                k1 = sat32(b * ONE / s);
            end
            post_st[ax] = sat32(xp + fix_mul(k0, e));
            post_st[ax + 2] = sat32(vp + fix_mul(k1, e));
            cov[ax*3] = sat32(a - fix_mul(k0, a));
            cov[ax*3+1] = sat32(b - fix_mul(k0, b));
            cov[ax*3+2] = sat32(c - fix_mul(k1, b));
        endfunction

        function void note_item(logic [1:0] kind, logic [63:0] d);
            longint f[4];
            track_out_t o;
            for (int i = 0; i < 4; i++) f[i] = longint'($signed(d[16*i +: 16]));
            if (kind == cvkt_pkg::KIND_START) begin
                for (int i = 0; i < 4; i++) begin
                    post_st[i] = sat32(f[i] * ONE);
                    pred_st[i] = post_st[i];
                end
                for (int i = 0; i < 2; i++) begin
                    cov[i*3] = ONE;
                    cov[i*3+1] = 0;
                    cov[i*3+2] = ONE;
                end
            end else if (kind == cvkt_pkg::KIND_MEASURE) begin
                filter_axis(0, 0, sat32(f[0] * ONE));
                filter_axis(1, 0, sat32(f[1] * ONE));
            end else if (kind == cvkt_pkg::KIND_COAST) begin
                filter_axis(0, 1, 0);
                filter_axis(1, 1, 0);
            end
            o.post_pos_x = to_pix(post_st[0]);
            o.post_pos_y = to_pix(post_st[1]);
            o.post_vel_x = to_pix(post_st[2]);
            o.post_vel_y = to_pix(post_st[3]);
            o.pred_pos_x = to_pix(pred_st[0]);
            o.pred_pos_y = to_pix(pred_st[1]);
            o.pred_vel_x = to_pix(pred_st[2]);
            o.pred_vel_y = to_pix(pred_st[3]);
            pending.push_back(o);
        endfunction

        function void check_result(logic [127:0] d);
            track_out_t got, exp_o;
            got = d;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %h", d);
                errors++;
                return;
            end
            exp_o = pending.pop_front();
            if (got.post_pos_x !== exp_o.post_pos_x) begin
                $error("post_pos_x exp %h got %h", exp_o.post_pos_x, got.post_pos_x); errors++; end
            if (got.post_pos_y !== exp_o.post_pos_y) begin
                $error("post_pos_y exp %h got %h", exp_o.post_pos_y, got.post_pos_y); errors++; end
            if (got.post_vel_x !== exp_o.post_vel_x) begin
                $error("post_vel_x exp %h got %h", exp_o.post_vel_x, got.post_vel_x); errors++; end
            if (got.post_vel_y !== exp_o.post_vel_y) begin
                $error("post_vel_y exp %h got %h", exp_o.post_vel_y, got.post_vel_y); errors++; end
            if (got.pred_pos_x !== exp_o.pred_pos_x) begin
                $error("pred_pos_x exp %h got %h", exp_o.pred_pos_x, got.pred_pos_x); errors++; end
            if (got.pred_pos_y !== exp_o.pred_pos_y) begin
                $error("pred_pos_y exp %h got %h", exp_o.pred_pos_y, got.pred_pos_y); errors++; end
            if (got.pred_vel_x !== exp_o.pred_vel_x) begin
                $error("pred_vel_x exp %h got %h", exp_o.pred_vel_x, got.pred_vel_x); errors++; end
            if (got.pred_vel_y !== exp_o.pred_vel_y) begin
                $error("pred_vel_y exp %h got %h", exp_o.pred_vel_y, got.pred_vel_y); errors++; end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;   // pos_x, pos_y, vel_x, vel_y
    logic [1:0]   s_tuser = '0;   // kind
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [127:0] m_tdata;        // post pos/vel x y, pred pos/vel x y
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    track_scoreboard sb = new();
    bit calm = 0;
    bit hold_long = 0;

    constant_velocity_kalman_tracker dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial begin : receiver
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_long) begin
                m_tready <= 0;
                repeat (2000) @(posedge aclk);
                hold_long = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 4);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(logic [1:0] kind, logic [15:0] px, logic [15:0] py,
                             logic [15:0] vx, logic [15:0] vy);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            n = $urandom_range(1, 4);
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= {vy, vx, py, px};
        @(posedge aclk iff s_tready);
    endtask

    task automatic finish_sends();
        s_tvalid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        finish_sends();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk iff cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rnd_small();
        return 16'($signed($urandom_range(0, 400)) - 200);
    endfunction

    task automatic random_run(int count, bit wide);
        logic [1:0] kind;
        logic [15:0] px, py;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0) kind = cvkt_pkg::KIND_START;
            else if ($urandom_range(0, 39) == 0) kind = KIND_UNUSED;
            else if ($urandom_range(0, 4) == 0) kind = cvkt_pkg::KIND_COAST;
            else kind = cvkt_pkg::KIND_MEASURE;
            if (wide || $urandom_range(0, 9) == 0) begin
                px = 16'($urandom);
                py = 16'($urandom);
            end else begin
                px = rnd_small();
                py = rnd_small();
            end
            if (wide) send_item(kind, px, py, 16'($urandom), 16'($urandom));
            else send_item(kind, px, py, rnd_small(), $urandom_range(0, 3) == 0 ?
                           16'($urandom) : rnd_small());
        end
    endtask

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // before any start, then extremes
        send_item(cvkt_pkg::KIND_MEASURE, 16'h7fff, 16'h8000, 16'd0, 16'd0);
        send_item(cvkt_pkg::KIND_COAST, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(KIND_UNUSED, 16'h1234, 16'h4321, 16'h1, 16'h2);
        send_item(cvkt_pkg::KIND_START, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_item(cvkt_pkg::KIND_MEASURE, 16'h8000, 16'h7fff, 16'd0, 16'd0);
        send_item(cvkt_pkg::KIND_COAST, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(cvkt_pkg::KIND_START, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_item(cvkt_pkg::KIND_MEASURE, 16'h7fff, 16'h8000, 16'hffff, 16'hffff);
        send_item(cvkt_pkg::KIND_START, 16'd10, -16'sd10, 16'd2, -16'sd3);
        for (int i = 0; i < 6; i++)
            send_item(cvkt_pkg::KIND_MEASURE, 16'(12 + 2*i), 16'(-13 - 3*i), 16'd0, 16'd0);
        send_item(cvkt_pkg::KIND_COAST, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(KIND_UNUSED, 16'd0, 16'd0, 16'd0, 16'd0);
        drain();

        // zero time step, zero process noise and unit measurement noise
        write_cfg(cvkt_pkg::REG_TIME_STEP, 32'd0);
        write_cfg(cvkt_pkg::REG_PROC_NOISE, 32'd0);
        write_cfg(cvkt_pkg::REG_MEAS_NOISE, 32'd1);
        send_item(cvkt_pkg::KIND_MEASURE, 16'd5, -16'sd5, 16'd0, 16'd0);
        send_item(cvkt_pkg::KIND_START, 16'd1, 16'd1, 16'd1, 16'd1);
        send_item(cvkt_pkg::KIND_MEASURE, 16'd3, 16'd4, 16'd0, 16'd0);
        random_run(150, 0);
        drain();

        // out of range index is ignored
        write_cfg(REG_UNUSED, 32'hffffffff);
        write_cfg(cvkt_pkg::REG_TIME_STEP, 32'd16777216);
        write_cfg(cvkt_pkg::REG_PROC_NOISE, 32'd65536);
        write_cfg(cvkt_pkg::REG_MEAS_NOISE, 32'd65536);
        random_run(250, 1);
        drain();

        write_cfg(cvkt_pkg::REG_TIME_STEP, 32'd32768);
        write_cfg(cvkt_pkg::REG_PROC_NOISE, 32'd1000);
        write_cfg(cvkt_pkg::REG_MEAS_NOISE, 32'd300);
        hold_long = 1;
        random_run(300, 0);
        drain();

        write_cfg(cvkt_pkg::REG_TIME_STEP, $urandom_range(0, 16777216));
        write_cfg(cvkt_pkg::REG_PROC_NOISE, $urandom_range(0, 65536));
        write_cfg(cvkt_pkg::REG_MEAS_NOISE, $urandom_range(1, 65536));
        random_run(400, 1'($urandom_range(0, 1)));
        drain();

        write_cfg(cvkt_pkg::REG_TIME_STEP, 32'd65536);
        write_cfg(cvkt_pkg::REG_PROC_NOISE, 32'd66);
        write_cfg(cvkt_pkg::REG_MEAS_NOISE, 32'd655);
        random_run(500, 0);
        calm = 1;
        random_run(200, 0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
